// ===== design/assert_macros.svh =====
// assertion macros used by the execute unit rtl
// no dependencies; users must have clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock, off while in reset
`define ECPU_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every clock, including reset
`define ECPU_CHECK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/ecpu_pkg.sv =====
// shared types, operation codes and helpers for the execute unit
// no dependencies
`default_nettype none

package ecpu_pkg;

    localparam int STACK_BYTES_DEF = 256;

    localparam logic [7:0] P_RESET  = 8'h24;
    localparam logic [7:0] SP_RESET = 8'hFD;
    localparam logic [7:0] P_PUSH_SET = 8'h30;
    localparam logic [7:0] P_PULL_MASK = 8'hEF;
    localparam logic [7:0] P_PULL_SET = 8'h20;

    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_B = 4;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    localparam logic [6:0] OP_ADC   = 7'd0;
    localparam logic [6:0] OP_SBC   = 7'd1;
    localparam logic [6:0] OP_ORA   = 7'd2;
    localparam logic [6:0] OP_SLO   = 7'd3;
    localparam logic [6:0] OP_ASL   = 7'd4;
    localparam logic [6:0] OP_AND   = 7'd5;
    localparam logic [6:0] OP_ROL   = 7'd6;
    localparam logic [6:0] OP_EOR   = 7'd7;
    localparam logic [6:0] OP_LSR   = 7'd8;
    localparam logic [6:0] OP_ROR   = 7'd9;
    localparam logic [6:0] OP_LDX   = 7'd10;
    localparam logic [6:0] OP_LDY   = 7'd11;
    localparam logic [6:0] OP_LDA   = 7'd12;
    localparam logic [6:0] OP_CMP   = 7'd13;
    localparam logic [6:0] OP_CPY   = 7'd14;
    localparam logic [6:0] OP_DCP   = 7'd15;
    localparam logic [6:0] OP_CPX   = 7'd16;
    localparam logic [6:0] OP_ISC   = 7'd17;
    localparam logic [6:0] OP_INC   = 7'd18;
    localparam logic [6:0] OP_DEC   = 7'd19;
    localparam logic [6:0] OP_LAX   = 7'd20;
    localparam logic [6:0] OP_SRE   = 7'd21;
    localparam logic [6:0] OP_RRA   = 7'd22;
    localparam logic [6:0] OP_RLA   = 7'd23;
    localparam logic [6:0] OP_ARR   = 7'd24;
    localparam logic [6:0] OP_AAC   = 7'd25;
    localparam logic [6:0] OP_BIT   = 7'd26;
    localparam logic [6:0] OP_JSR   = 7'd27;
    localparam logic [6:0] OP_BRK   = 7'd28;
    localparam logic [6:0] OP_BPL   = 7'd29;
    localparam logic [6:0] OP_BEQ   = 7'd30;
    localparam logic [6:0] OP_BNE   = 7'd31;
    localparam logic [6:0] OP_ASL_A = 7'd32;
    localparam logic [6:0] OP_AXA   = 7'd33;
    localparam logic [6:0] OP_CLC   = 7'd34;
    localparam logic [6:0] OP_KIL   = 7'd35;
    localparam logic [6:0] OP_PHP   = 7'd38;
    localparam logic [6:0] OP_PLP   = 7'd39;
    localparam logic [6:0] OP_ROL_A = 7'd40;
    localparam logic [6:0] OP_RTI   = 7'd41;
    localparam logic [6:0] OP_BMI   = 7'd42;
    localparam logic [6:0] OP_LSR_A = 7'd44;
    localparam logic [6:0] OP_ASR   = 7'd45;
    localparam logic [6:0] OP_BVC   = 7'd46;
    localparam logic [6:0] OP_RTS   = 7'd47;
    localparam logic [6:0] OP_PLA   = 7'd48;
    localparam logic [6:0] OP_ROR_A = 7'd49;
    localparam logic [6:0] OP_BVS   = 7'd50;
    localparam logic [6:0] OP_SEI   = 7'd51;
    localparam logic [6:0] OP_STA   = 7'd52;
    localparam logic [6:0] OP_AAX   = 7'd53;
    localparam logic [6:0] OP_STX   = 7'd54;
    localparam logic [6:0] OP_TYA   = 7'd55;
    localparam logic [6:0] OP_TXS   = 7'd56;
    localparam logic [6:0] OP_XAS   = 7'd57;
    localparam logic [6:0] OP_SYA   = 7'd58;
    localparam logic [6:0] OP_SXA   = 7'd59;
    localparam logic [6:0] OP_TAY   = 7'd60;
    localparam logic [6:0] OP_TAX   = 7'd61;
    localparam logic [6:0] OP_ATX   = 7'd62;
    localparam logic [6:0] OP_BCS   = 7'd63;
    localparam logic [6:0] OP_CLV   = 7'd64;
    localparam logic [6:0] OP_TSX   = 7'd65;
    localparam logic [6:0] OP_LAR   = 7'd66;
    localparam logic [6:0] OP_INY   = 7'd67;
    localparam logic [6:0] OP_DEX   = 7'd68;
    localparam logic [6:0] OP_AXS   = 7'd69;
    localparam logic [6:0] OP_CLD   = 7'd70;
    localparam logic [6:0] OP_INX   = 7'd71;
    localparam logic [6:0] OP_SED   = 7'd72;
    localparam logic [6:0] OP_XAA   = 7'd73;
    localparam logic [6:0] OP_STY   = 7'd74;
    localparam logic [6:0] OP_DEY   = 7'd75;
    localparam logic [6:0] OP_TXA   = 7'd76;
    localparam logic [6:0] OP_BCC   = 7'd77;
    localparam logic [6:0] OP_SEC   = 7'd78;
    localparam logic [6:0] OP_PHA   = 7'd79;
    localparam logic [6:0] OP_CLI   = 7'd80;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] p;
        logic [7:0] sp;
    } regs_t;

    typedef struct packed {
        regs_t       nxt;
        logic        we;
        logic [7:0]  wd;
        logic        pcl;
        logic [15:0] npc;
        logic [1:0]  extra;
        logic        halt;
        logic        push_en;
        logic [7:0]  push_data;
    } alu_res_t;

    typedef struct packed {
        logic        we;
        logic [7:0]  wd;
        logic        pcl;
        logic [15:0] npc;
        logic [1:0]  extra;
        logic        halted;
        regs_t       regs;
    } out_t;

    function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] r;
        begin
            r = p;
            r[FLAG_N] = v[7];
            r[FLAG_Z] = (v == 8'h00);
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/ecpu_ram.sv =====
// generic single-clock ram, one write and one read port, registered read
// no dependencies
`default_nettype none

module ecpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/ecpu_alu.sv =====
// combinational instruction datapath: alu, flags, branches, one-byte pushes
// depends on ecpu_pkg
`default_nettype none

module ecpu_alu (
    input  wire logic [6:0]         func,
    input  wire logic [7:0]         operand,
    input  wire logic [15:0]        target,
    input  wire logic [15:0]        pc,
    input  wire ecpu_pkg::regs_t    cur,
    output ecpu_pkg::alu_res_t      res
);

    import ecpu_pkg::*;

    logic [9:0] sum;
    logic [7:0] t;
    logic       branch;
    logic       take;

    function automatic logic [9:0] add8(input logic [7:0] a, input logic [7:0] b,
                                        input logic c);
        logic [8:0] s;
        begin
            s = {1'b0, a} + {1'b0, b} + {8'h00, c};
            return {((a ^ s[7:0]) & (b ^ s[7:0]) & 8'h80) != 8'h00, s[8], s[7:0]};
        end
    endfunction

    always_comb
    begin
        res = '0;
        res.nxt = cur;
        sum = '0;
        t = '0;
        branch = 1'b0;
        take = 1'b0;
        unique case (func) inside
            OP_ADC:
            begin
                sum = add8(cur.a, operand, cur.p[FLAG_C]);
                res.nxt.a = sum[7:0];
                res.nxt.p[FLAG_V] = sum[9];
                res.nxt.p[FLAG_C] = sum[8];
                res.nxt.p = set_nz(res.nxt.p, sum[7:0]);
            end
            OP_SBC:
            begin
                sum = add8(cur.a, ~operand, cur.p[FLAG_C]);
                res.nxt.a = sum[7:0];
                res.nxt.p[FLAG_V] = sum[9];
                res.nxt.p[FLAG_C] = sum[8];
                res.nxt.p = set_nz(res.nxt.p, sum[7:0]);
            end
            OP_ORA:
            begin
                res.nxt.a = cur.a | operand;
                res.nxt.p = set_nz(cur.p, res.nxt.a);
            end
            OP_SLO:
            begin
                res.we = 1'b1;
                res.wd = {operand[6:0], 1'b0};
                res.nxt.p[FLAG_C] = operand[7];
                res.nxt.a = cur.a | res.wd;
                res.nxt.p = set_nz(res.nxt.p, res.nxt.a);
            end
            OP_ASL:
            begin
                res.we = 1'b1;
                res.wd = {operand[6:0], 1'b0};
                res.nxt.p[FLAG_C] = operand[7];
                res.nxt.p = set_nz(res.nxt.p, res.wd);
            end
            OP_AND, OP_XAS, OP_SYA, OP_SXA, OP_XAA:
            begin
                res.nxt.a = cur.a & operand;
                res.nxt.p = set_nz(cur.p, res.nxt.a);
            end
            OP_ROL:
            begin
                res.we = 1'b1;
                res.wd = {operand[6:0], cur.p[FLAG_C]};
                res.nxt.p[FLAG_C] = operand[7];
                res.nxt.p = set_nz(res.nxt.p, res.wd);
            end
            OP_EOR:
            begin
                res.nxt.a = cur.a ^ operand;
                res.nxt.p = set_nz(cur.p, res.nxt.a);
            end
            OP_LSR:
            begin
                res.we = 1'b1;
                res.wd = {1'b0, operand[7:1]};
                res.nxt.p[FLAG_C] = operand[0];
                res.nxt.p = set_nz(res.nxt.p, res.wd);
            end
            OP_ROR:
            begin
                res.we = 1'b1;
                res.wd = {cur.p[FLAG_C], operand[7:1]};
                res.nxt.p[FLAG_C] = operand[0];
                res.nxt.p = set_nz(res.nxt.p, res.wd);
            end
            OP_LDX:
            begin
                res.nxt.x = operand;
                res.nxt.p = set_nz(cur.p, operand);
            end
            OP_LDY:
            begin
                res.nxt.y = operand;
                res.nxt.p = set_nz(cur.p, operand);
            end
            OP_LDA:
            begin
                res.nxt.a = operand;
                res.nxt.p = set_nz(cur.p, operand);
            end
            OP_CMP:
            begin
                res.nxt.p[FLAG_C] = (cur.a >= operand);
                res.nxt.p = set_nz(res.nxt.p, cur.a - operand);
            end
            OP_CPY:
            begin
                res.nxt.p[FLAG_C] = (cur.y >= operand);
                res.nxt.p = set_nz(res.nxt.p, cur.y - operand);
            end
            OP_CPX:
            begin
                res.nxt.p[FLAG_C] = (cur.x >= operand);
                res.nxt.p = set_nz(res.nxt.p, cur.x - operand);
            end
            OP_DCP:
            begin
                res.we = 1'b1;
                res.wd = operand - 8'd1;
                res.nxt.p[FLAG_C] = (cur.a >= res.wd);
                res.nxt.p = set_nz(res.nxt.p, cur.a - res.wd);
            end
            OP_ISC:
            begin
                res.we = 1'b1;
                res.wd = operand + 8'd1;
                sum = add8(cur.a, ~res.wd, cur.p[FLAG_C]);
                res.nxt.a = sum[7:0];
                res.nxt.p[FLAG_V] = sum[9];
                res.nxt.p[FLAG_C] = sum[8];
                res.nxt.p = set_nz(res.nxt.p, sum[7:0]);
            end
            OP_INC:
            begin
                res.we = 1'b1;
                res.wd = operand + 8'd1;
                res.nxt.p = set_nz(cur.p, res.wd);
            end
            OP_DEC:
            begin
                res.we = 1'b1;
                res.wd = operand - 8'd1;
                res.nxt.p = set_nz(cur.p, res.wd);
            end
            OP_LAX, OP_ATX:
            begin
                res.nxt.a = operand;
                res.nxt.x = operand;
                res.nxt.p = set_nz(cur.p, operand);
            end
            OP_SRE:
            begin
                res.we = 1'b1;
                res.wd = {1'b0, operand[7:1]};
                res.nxt.p[FLAG_C] = operand[0];
                res.nxt.a = cur.a ^ res.wd;
                res.nxt.p = set_nz(res.nxt.p, res.nxt.a);
            end
            OP_RRA:
            begin
                res.we = 1'b1;
                res.wd = {cur.p[FLAG_C], operand[7:1]};
                sum = add8(cur.a, res.wd, operand[0]);
                res.nxt.a = sum[7:0];
                res.nxt.p[FLAG_V] = sum[9];
                res.nxt.p[FLAG_C] = sum[8];
                res.nxt.p = set_nz(res.nxt.p, sum[7:0]);
            end
            OP_RLA:
            begin
                res.we = 1'b1;
                res.wd = {operand[6:0], cur.p[FLAG_C]};
                res.nxt.p[FLAG_C] = operand[7];
                res.nxt.a = cur.a & res.wd;
                res.nxt.p = set_nz(res.nxt.p, res.nxt.a);
            end
            OP_ARR:
            begin
                t = cur.a & operand;
                res.nxt.a = {cur.p[FLAG_C], t[7:1]};
                res.nxt.p = set_nz(cur.p, res.nxt.a);
                res.nxt.p[FLAG_C] = res.nxt.a[6];
                res.nxt.p[FLAG_V] = res.nxt.a[6] ^ res.nxt.a[5];
            end
            OP_AAC:
            begin
                res.nxt.a = cur.a & operand;
                res.nxt.p = set_nz(cur.p, res.nxt.a);
                res.nxt.p[FLAG_C] = res.nxt.a[7];
            end
            OP_BIT:
            begin
                res.nxt.p[FLAG_V] = operand[6];
                res.nxt.p[FLAG_N] = operand[7];
                res.nxt.p[FLAG_Z] = ((cur.a & operand) == 8'h00);
            end
            OP_BPL:
            begin
                branch = 1'b1;
                take = !cur.p[FLAG_N];
            end
            OP_BMI:
            begin
                branch = 1'b1;
                take = cur.p[FLAG_N];
            end
            OP_BEQ:
            begin
                branch = 1'b1;
                take = cur.p[FLAG_Z];
            end
            OP_BNE:
            begin
                branch = 1'b1;
                take = !cur.p[FLAG_Z];
            end
            OP_BVC:
            begin
                branch = 1'b1;
                take = !cur.p[FLAG_V];
            end
            OP_BVS:
            begin
                branch = 1'b1;
                take = cur.p[FLAG_V];
            end
            OP_BCS:
            begin
                branch = 1'b1;
                take = cur.p[FLAG_C];
            end
            OP_BCC:
            begin
                branch = 1'b1;
                take = !cur.p[FLAG_C];
            end
            OP_ASL_A:
            begin
                res.nxt.p[FLAG_C] = cur.a[7];
                res.nxt.a = {cur.a[6:0], 1'b0};
                res.nxt.p = set_nz(res.nxt.p, res.nxt.a);
            end
            OP_ROL_A:
            begin
                res.nxt.p[FLAG_C] = cur.a[7];
                res.nxt.a = {cur.a[6:0], cur.p[FLAG_C]};
                res.nxt.p = set_nz(res.nxt.p, res.nxt.a);
            end
            OP_LSR_A:
            begin
                res.nxt.p[FLAG_C] = cur.a[0];
                res.nxt.a = {1'b0, cur.a[7:1]};
                res.nxt.p = set_nz(res.nxt.p, res.nxt.a);
            end
            OP_ROR_A:
            begin
                res.nxt.p[FLAG_C] = cur.a[0];
                res.nxt.a = {cur.p[FLAG_C], cur.a[7:1]};
                res.nxt.p = set_nz(res.nxt.p, res.nxt.a);
            end
            OP_ASR:
            begin
                t = cur.a & operand;
                res.nxt.p[FLAG_C] = t[0];
                res.nxt.a = {1'b0, t[7:1]};
                res.nxt.p = set_nz(res.nxt.p, res.nxt.a);
            end
            OP_AXA:
            begin
                res.nxt.x = cur.x & cur.a;
                res.we = 1'b1;
                res.wd = res.nxt.x & 8'h07;
            end
            OP_CLC: res.nxt.p[FLAG_C] = 1'b0;
            OP_SEC: res.nxt.p[FLAG_C] = 1'b1;
            OP_CLI: res.nxt.p[FLAG_I] = 1'b0;
            OP_SEI: res.nxt.p[FLAG_I] = 1'b1;
            OP_CLV: res.nxt.p[FLAG_V] = 1'b0;
            OP_CLD: res.nxt.p[FLAG_D] = 1'b0;
            OP_SED: res.nxt.p[FLAG_D] = 1'b1;
            OP_KIL: res.halt = 1'b1;
            OP_PHP:
            begin
                res.push_en = 1'b1;
                res.push_data = cur.p | P_PUSH_SET;
                res.nxt.sp = cur.sp - 8'd1;
            end
            OP_PHA:
            begin
                res.push_en = 1'b1;
                res.push_data = cur.a;
                res.nxt.sp = cur.sp - 8'd1;
            end
            OP_STA:
            begin
                res.we = 1'b1;
                res.wd = cur.a;
            end
            OP_AAX:
            begin
                res.we = 1'b1;
                res.wd = cur.x & cur.a;
            end
            OP_STX:
            begin
                res.we = 1'b1;
                res.wd = cur.x;
            end
            OP_STY:
            begin
                res.we = 1'b1;
                res.wd = cur.y;
            end
            OP_TYA:
            begin
                res.nxt.a = cur.y;
                res.nxt.p = set_nz(cur.p, cur.y);
            end
            OP_TXA:
            begin
                res.nxt.a = cur.x;
                res.nxt.p = set_nz(cur.p, cur.x);
            end
            OP_TAY:
            begin
                res.nxt.y = cur.a;
                res.nxt.p = set_nz(cur.p, cur.a);
            end
            OP_TAX:
            begin
                res.nxt.x = cur.a;
                res.nxt.p = set_nz(cur.p, cur.a);
            end
            OP_TXS: res.nxt.sp = cur.x;
            OP_TSX:
            begin
                res.nxt.x = cur.sp;
                res.nxt.p = set_nz(cur.p, cur.sp);
            end
            OP_LAR:
            begin
                res.nxt.a = operand;
                res.nxt.x = cur.sp;
                res.nxt.p = set_nz(cur.p, cur.sp);
            end
            OP_INY:
            begin
                res.nxt.y = cur.y + 8'd1;
                res.nxt.p = set_nz(cur.p, res.nxt.y);
            end
            OP_DEY:
            begin
                res.nxt.y = cur.y - 8'd1;
                res.nxt.p = set_nz(cur.p, res.nxt.y);
            end
            OP_INX:
            begin
                res.nxt.x = cur.x + 8'd1;
                res.nxt.p = set_nz(cur.p, res.nxt.x);
            end
            OP_DEX:
            begin
                res.nxt.x = cur.x - 8'd1;
                res.nxt.p = set_nz(cur.p, res.nxt.x);
            end
            OP_AXS:
            begin
                t = cur.a & cur.x;
                res.nxt.p[FLAG_C] = (t >= operand);
                res.nxt.x = t - operand;
                res.nxt.p = set_nz(res.nxt.p, res.nxt.x);
            end
            default:
            begin
                res.nxt = cur;
            end
        endcase
        if (branch && take)
        begin
            res.pcl = 1'b1;
            res.npc = target;
            res.extra = (target[15:8] != pc[15:8]) ? 2'd2 : 2'd1;
        end
    end

endmodule

`default_nettype wire

// ===== design/eight_bit_cpu_execute_unit.sv =====
// execute unit: one request per cycle, while not stalled, for register, alu, branch and
// one-byte push ops; result registered, held in a skid stage while the output is stalled.
// jsr, pla, plp, brk, rts, rti run through their S_ states: one stack ram access a cycle.
// reset clears a, x, y, lock, sets flags to 0x24 and sp to 0xfd; stack ram is not cleared.
// depends on ecpu_pkg, ecpu_alu, ecpu_ram, assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module eight_bit_cpu_execute_unit #(
    parameter int STACK_BYTES = ecpu_pkg::STACK_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [6:0]  func,
    input  wire logic [7:0]  operand,
    input  wire logic [15:0] target,
    input  wire logic [15:0] pc,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             write_enable,
    output logic [7:0]       write_data,
    output logic             pc_load,
    output logic [15:0]      new_pc,
    output logic [1:0]       extra_cycles,
    output logic             halted,
    output logic [7:0]       acc_out,
    output logic [7:0]       x_out,
    output logic [7:0]       y_out,
    output logic [7:0]       flags_out,
    output logic [7:0]       sp_out
);

    import ecpu_pkg::*;

    localparam int AW = $clog2(STACK_BYTES);
    localparam logic [16:0] RECIP = 17'(65536 / STACK_BYTES);

    typedef enum logic [3:0] {
        S_RUN, S_BRK1, S_BRK2, S_JSR1, S_PLA, S_PLP,
        S_RTS1, S_RTS2, S_RTI1, S_RTI2, S_RTI3
    } state_t;

    state_t      state_reg, state_next;
    regs_t       regs_reg, regs_next;
    logic        halt_reg, halt_next;
    logic [7:0]  lo_reg, lo_next;
    logic [15:0] tgt_reg, tgt_next;
    out_t        main_reg, skid_reg;
    logic        out_valid_reg, skid_valid_reg;

    alu_res_t    alu;
    out_t        emit_res;
    logic        emit;
    logic        accept;
    logic        adv;
    logic        take_out;
    logic        ram_we, ram_re;
    logic [7:0]  ram_wdata, ram_rdata;
    logic [7:0]  sp_addr;
    logic [7:0]  p_brk;
    logic [15:0] pc_inc;
    logic [24:0] quo_prod;
    logic [11:0] rem_raw, rem_fix;
    logic [AW-1:0] ram_addr;

    ecpu_alu u_alu (
        .func    (func),
        .operand (operand),
        .target  (target),
        .pc      (pc),
        .cur     (regs_reg),
        .res     (alu)
    );

    // stack index = sp mod STACK_BYTES, reciprocal then one correction
    assign quo_prod = 25'(sp_addr) * 25'(RECIP);
    assign rem_raw = 12'(sp_addr) - 12'(quo_prod[23:16]) * 12'(STACK_BYTES);
    assign rem_fix = (rem_raw >= 12'(STACK_BYTES)) ? rem_raw - 12'(STACK_BYTES) : rem_raw;
    assign ram_addr = rem_fix[AW-1:0];

    ecpu_ram #(
        .WIDTH (8),
        .DEPTH (STACK_BYTES)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    assign adv = !skid_valid_reg;
    assign in_stall = (state_reg != S_RUN) || skid_valid_reg;
    assign accept = in_valid && !in_stall;
    assign take_out = out_valid_reg && !out_stall;

    always_comb
    begin
        state_next = state_reg;
        regs_next = regs_reg;
        halt_next = halt_reg;
        lo_next = lo_reg;
        tgt_next = tgt_reg;
        ram_we = 1'b0;
        ram_re = 1'b0;
        ram_wdata = regs_reg.a;
        sp_addr = regs_reg.sp;
        emit = 1'b0;
        emit_res = '0;
        p_brk = regs_reg.p;
        p_brk[FLAG_B] = 1'b1;
        pc_inc = pc + 16'd1;
        unique case (state_reg)
            S_RUN:
            begin
                if (accept)
                begin
                    if (halt_reg)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        case (func) inside
                            OP_BRK, OP_JSR:
                            begin
                                if (func == OP_JSR)
                                begin
                                    pc_inc = pc + 16'd2;
                                end
                                ram_we = 1'b1;
                                ram_wdata = pc_inc[15:8];
                                lo_next = pc_inc[7:0];
                                tgt_next = target;
                                regs_next.sp = regs_reg.sp - 8'd1;
                                state_next = (func == OP_JSR) ? S_JSR1 : S_BRK1;
                            end
                            OP_PLA, OP_PLP, OP_RTS, OP_RTI:
                            begin
                                ram_re = 1'b1;
                                sp_addr = regs_reg.sp + 8'd1;
                                regs_next.sp = sp_addr;
                                if (func == OP_PLA)
                                begin
                                    state_next = S_PLA;
                                end
                                else if (func == OP_PLP)
                                begin
                                    state_next = S_PLP;
                                end
                                else if (func == OP_RTS)
                                begin
                                    state_next = S_RTS1;
                                end
                                else
                                begin
                                    state_next = S_RTI1;
                                end
                            end
                            default:
                            begin
                                regs_next = alu.nxt;
                                halt_next = alu.halt;
                                ram_we = alu.push_en;
                                ram_wdata = alu.push_data;
                                emit = 1'b1;
                                emit_res.we = alu.we;
                                emit_res.wd = alu.wd;
                                emit_res.pcl = alu.pcl;
                                emit_res.npc = alu.npc;
                                emit_res.extra = alu.extra;
                            end
                        endcase
                    end
                end
            end
            S_BRK1:
            begin
                if (adv)
                begin
                    ram_we = 1'b1;
                    ram_wdata = lo_reg;
                    regs_next.sp = regs_reg.sp - 8'd1;
                    state_next = S_BRK2;
                end
            end
            S_BRK2:
            begin
                if (adv)
                begin
                    ram_we = 1'b1;
                    ram_wdata = p_brk;
                    regs_next.sp = regs_reg.sp - 8'd1;
                    regs_next.p = p_brk;
                    regs_next.p[FLAG_I] = 1'b1;
                    emit = 1'b1;
                    emit_res.pcl = 1'b1;
                    emit_res.npc = tgt_reg;
                    state_next = S_RUN;
                end
            end
            S_JSR1:
            begin
                if (adv)
                begin
                    ram_we = 1'b1;
                    ram_wdata = lo_reg;
                    regs_next.sp = regs_reg.sp - 8'd1;
                    emit = 1'b1;
                    emit_res.pcl = 1'b1;
                    emit_res.npc = tgt_reg;
                    state_next = S_RUN;
                end
            end
            S_PLA:
            begin
                if (adv)
                begin
                    regs_next.a = ram_rdata;
                    regs_next.p = set_nz(regs_reg.p, ram_rdata);
                    emit = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_PLP:
            begin
                if (adv)
                begin
                    regs_next.p = (ram_rdata & P_PULL_MASK) | P_PULL_SET;
                    emit = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RTS1, S_RTI2:
            begin
                if (adv)
                begin
                    lo_next = ram_rdata;
                    ram_re = 1'b1;
                    sp_addr = regs_reg.sp + 8'd1;
                    regs_next.sp = sp_addr;
                    state_next = (state_reg == S_RTS1) ? S_RTS2 : S_RTI3;
                end
            end
            S_RTI1:
            begin
                if (adv)
                begin
                    regs_next.p = ram_rdata | P_PULL_SET;
                    ram_re = 1'b1;
                    sp_addr = regs_reg.sp + 8'd1;
                    regs_next.sp = sp_addr;
                    state_next = S_RTI2;
                end
            end
            S_RTS2, S_RTI3:
            begin
                if (adv)
                begin
                    emit = 1'b1;
                    emit_res.pcl = 1'b1;
                    emit_res.npc = {ram_rdata, lo_reg};
                    if (state_reg == S_RTS2)
                    begin
                        emit_res.npc = {ram_rdata, lo_reg} + 16'd1;
                    end
                    state_next = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
        emit_res.halted = halt_next;
        emit_res.regs = regs_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RUN;
            regs_reg <= '{a: 8'h00, x: 8'h00, y: 8'h00, p: P_RESET, sp: SP_RESET};
            halt_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            regs_reg <= regs_next;
            halt_reg <= halt_next;
            if (take_out)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else if (!emit)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
            else if (emit)
            begin
                if (!out_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        tgt_reg <= tgt_next;
        if (take_out)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
            end
            else if (emit)
            begin
                main_reg <= emit_res;
            end
        end
        else if (emit)
        begin
            if (!out_valid_reg)
            begin
                main_reg <= emit_res;
            end
            else
            begin
                skid_reg <= emit_res;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign write_enable = main_reg.we;
    assign write_data = main_reg.wd;
    assign pc_load = main_reg.pcl;
    assign new_pc = main_reg.npc;
    assign extra_cycles = main_reg.extra;
    assign halted = main_reg.halted;
    assign acc_out = main_reg.regs.a;
    assign x_out = main_reg.regs.x;
    assign y_out = main_reg.regs.y;
    assign flags_out = main_reg.regs.p;
    assign sp_out = main_reg.regs.sp;

    `ECPU_CHECK(a_skid_needs_main, skid_valid_reg |-> out_valid_reg, "skid full, output empty")
    `ECPU_CHECK(a_seq_blocks_input, (state_reg != S_RUN) |-> in_stall, "input open mid sequence")
    `ECPU_CHECK(a_lock_sticks, halt_reg |=> halt_reg, "lock mark dropped")
    `ECPU_CHECK_ALWAYS(a_one_ram_access, !(ram_we && ram_re), "stack read and write together")

endmodule

`default_nettype wire

// ===== dv/eight_bit_cpu_execute_unit_tb.sv =====
// testbench for eight_bit_cpu_execute_unit: directed table, then random instruction stream
// checked against a cycle-free predictor of the register state and stack page
// depends on ecpu_pkg and the execute unit rtl
`timescale 1ns / 1ps

module eight_bit_cpu_execute_unit_tb;
    import ecpu_pkg::*;

    localparam logic [6:0] OP_DOP     = 7'd36;
    localparam logic [6:0] OP_NOP     = 7'd37;
    localparam logic [6:0] OP_TOP     = 7'd43;
    localparam logic [6:0] OP_UNKNOWN = 7'd127;
    localparam int         NUM_RANDOM = 1750;

    typedef struct packed {
        logic        we;
        logic [7:0]  wd;
        logic        pcl;
        logic [15:0] npc;
        logic [1:0]  extra;
        logic        halted;
        logic [7:0]  a;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  p;
        logic [7:0]  sp;
    } cpu_result_t;

    typedef struct packed {
        logic [6:0]  op;
        logic [7:0]  opnd;
        logic [15:0] tgt;
        logic [15:0] pcv;
        logic        typed;
        cpu_result_t want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [6:0]  func;
    logic [7:0]  operand;
    logic [15:0] target;
    logic [15:0] pc;
    logic        out_valid;
    logic        out_stall;
    logic        write_enable;
    logic [7:0]  write_data;
    logic        pc_load;
    logic [15:0] new_pc;
    logic [1:0]  extra_cycles;
    logic        halted;
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  flags_out;
    logic [7:0]  sp_out;

    eight_bit_cpu_execute_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .operand(operand), .target(target), .pc(pc),
        .out_valid(out_valid), .out_stall(out_stall),
        .write_enable(write_enable), .write_data(write_data),
        .pc_load(pc_load), .new_pc(new_pc), .extra_cycles(extra_cycles),
        .halted(halted), .acc_out(acc_out), .x_out(x_out), .y_out(y_out),
        .flags_out(flags_out), .sp_out(sp_out)
    );

    // predicted cpu state
    logic [7:0] acc_q, xr_q, yr_q, ps_q, sp_q;
    logic       locked_q;
    logic [7:0] stack_mem [256];
    bit         stack_known [256];

    cpu_result_t expected_results[$];
    bit          failed;
    logic        in_stall_s;
    logic        res_valid_s, res_stall_s;
    cpu_result_t res_s;
    int          burst_left;
    int          stall_mode;
    int          stall_count;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("FAIL");
        $finish;
    end

    function automatic logic [7:0] with_nz(input logic [7:0] p, input logic [7:0] v);
        with_nz = p;
        with_nz[FLAG_N] = v[7];
        with_nz[FLAG_Z] = (v == 8'h00);
    endfunction

    function automatic void stack_push(input logic [7:0] v);
        stack_mem[sp_q] = v;
        stack_known[sp_q] = 1'b1;
        sp_q = sp_q - 8'd1;
    endfunction

    function automatic logic [7:0] stack_pull();
        sp_q = sp_q + 8'd1;
        return stack_mem[sp_q];
    endfunction

    function automatic void add_with_carry(input logic [7:0] v);
        logic [8:0] sum;
        sum = {1'b0, acc_q} + {1'b0, v} + {8'd0, ps_q[FLAG_C]};
        ps_q[FLAG_V] = (acc_q[7] ^ sum[7]) & (v[7] ^ sum[7]);
        ps_q[FLAG_C] = sum[8];
        acc_q = sum[7:0];
        ps_q = with_nz(ps_q, acc_q);
    endfunction

    function automatic void compare(input logic [7:0] r, input logic [7:0] v);
        ps_q[FLAG_C] = (r >= v);
        ps_q = with_nz(ps_q, r - v);
    endfunction

    function automatic logic [7:0] shift_left(input logic [7:0] v, input logic cin);
        ps_q[FLAG_C] = v[7];
        shift_left = {v[6:0], cin};
        ps_q = with_nz(ps_q, shift_left);
    endfunction

    function automatic logic [7:0] shift_right(input logic [7:0] v, input logic cin);
        ps_q[FLAG_C] = v[0];
        shift_right = {cin, v[7:1]};
        ps_q = with_nz(ps_q, shift_right);
    endfunction

    function automatic cpu_result_t execute_instr(input logic [6:0] op, input logic [7:0] v,
                                                  input logic [15:0] tgt,
                                                  input logic [15:0] pcv);
        cpu_result_t r;
        logic [15:0] w;
        logic [7:0]  t;
        logic        branch, take;
        r = '0;
        branch = 1'b0;
        take = 1'b0;
        if (!locked_q)
        begin
            case (op)
                OP_ADC: add_with_carry(v);
                OP_SBC: add_with_carry(~v);
                OP_ORA: begin acc_q |= v; ps_q = with_nz(ps_q, acc_q); end
                OP_SLO:
                begin
                    r.wd = shift_left(v, 1'b0); r.we = 1'b1;
                    acc_q |= r.wd; ps_q = with_nz(ps_q, acc_q);
                end
                OP_ASL: begin r.wd = shift_left(v, 1'b0); r.we = 1'b1; end
                OP_AND: begin acc_q &= v; ps_q = with_nz(ps_q, acc_q); end
                OP_ROL: begin r.wd = shift_left(v, ps_q[FLAG_C]); r.we = 1'b1; end
                OP_EOR: begin acc_q ^= v; ps_q = with_nz(ps_q, acc_q); end
                OP_LSR: begin r.wd = shift_right(v, 1'b0); r.we = 1'b1; end
                OP_ROR: begin r.wd = shift_right(v, ps_q[FLAG_C]); r.we = 1'b1; end
                OP_LDX: begin xr_q = v; ps_q = with_nz(ps_q, v); end
                OP_LDY: begin yr_q = v; ps_q = with_nz(ps_q, v); end
                OP_LDA: begin acc_q = v; ps_q = with_nz(ps_q, v); end
                OP_CMP: compare(acc_q, v);
                OP_CPY: compare(yr_q, v);
                OP_DCP: begin r.wd = v - 8'd1; r.we = 1'b1; compare(acc_q, r.wd); end
                OP_CPX: compare(xr_q, v);
                OP_ISC: begin r.wd = v + 8'd1; r.we = 1'b1; add_with_carry(~r.wd); end
                OP_INC: begin r.wd = v + 8'd1; r.we = 1'b1; ps_q = with_nz(ps_q, r.wd); end
                OP_DEC: begin r.wd = v - 8'd1; r.we = 1'b1; ps_q = with_nz(ps_q, r.wd); end
                OP_LAX, OP_ATX: begin acc_q = v; xr_q = v; ps_q = with_nz(ps_q, v); end
                OP_SRE:
                begin
                    r.wd = shift_right(v, 1'b0); r.we = 1'b1;
                    acc_q ^= r.wd; ps_q = with_nz(ps_q, acc_q);
                end
                OP_RRA:
                begin
                    r.wd = shift_right(v, ps_q[FLAG_C]); r.we = 1'b1;
                    add_with_carry(r.wd);
                end
                OP_RLA:
                begin
                    r.wd = shift_left(v, ps_q[FLAG_C]); r.we = 1'b1;
                    acc_q &= r.wd; ps_q = with_nz(ps_q, acc_q);
                end
                OP_ARR:
                begin
                    t = acc_q & v;
                    acc_q = {ps_q[FLAG_C], t[7:1]};
                    ps_q = with_nz(ps_q, acc_q);
                    ps_q[FLAG_C] = acc_q[6];
                    ps_q[FLAG_V] = acc_q[6] ^ acc_q[5];
                end
                OP_AAC:
                begin
                    acc_q &= v; ps_q = with_nz(ps_q, acc_q);
                    ps_q[FLAG_C] = acc_q[7];
                end
                OP_BIT:
                begin
                    ps_q[FLAG_V] = v[6];
                    ps_q[FLAG_N] = v[7];
                    ps_q[FLAG_Z] = ((acc_q & v) == 8'h00);
                end
                OP_JSR:
                begin
                    w = pcv + 16'd2;
                    stack_push(w[15:8]); stack_push(w[7:0]);
                    r.pcl = 1'b1; r.npc = tgt;
                end
                OP_BRK:
                begin
                    w = pcv + 16'd1;
                    stack_push(w[15:8]); stack_push(w[7:0]);
                    ps_q[FLAG_B] = 1'b1;
                    stack_push(ps_q);
                    ps_q[FLAG_I] = 1'b1;
                    r.pcl = 1'b1; r.npc = tgt;
                end
                OP_BPL: begin branch = 1'b1; take = !ps_q[FLAG_N]; end
                OP_BMI: begin branch = 1'b1; take = ps_q[FLAG_N]; end
                OP_BEQ: begin branch = 1'b1; take = ps_q[FLAG_Z]; end
                OP_BNE: begin branch = 1'b1; take = !ps_q[FLAG_Z]; end
                OP_BVC: begin branch = 1'b1; take = !ps_q[FLAG_V]; end
                OP_BVS: begin branch = 1'b1; take = ps_q[FLAG_V]; end
                OP_BCC: begin branch = 1'b1; take = !ps_q[FLAG_C]; end
                OP_BCS: begin branch = 1'b1; take = ps_q[FLAG_C]; end
                OP_ASL_A: acc_q = shift_left(acc_q, 1'b0);
                OP_ROL_A: acc_q = shift_left(acc_q, ps_q[FLAG_C]);
                OP_LSR_A: acc_q = shift_right(acc_q, 1'b0);
                OP_ROR_A: acc_q = shift_right(acc_q, ps_q[FLAG_C]);
                OP_AXA: begin xr_q &= acc_q; r.wd = xr_q & 8'h07; r.we = 1'b1; end
                OP_CLC: ps_q[FLAG_C] = 1'b0;
                OP_SEC: ps_q[FLAG_C] = 1'b1;
                OP_CLI: ps_q[FLAG_I] = 1'b0;
                OP_SEI: ps_q[FLAG_I] = 1'b1;
                OP_CLV: ps_q[FLAG_V] = 1'b0;
                OP_CLD: ps_q[FLAG_D] = 1'b0;
                OP_SED: ps_q[FLAG_D] = 1'b1;
                OP_KIL: locked_q = 1'b1;
                OP_PHP: stack_push(ps_q | P_PUSH_SET);
                OP_PLP: ps_q = (stack_pull() & P_PULL_MASK) | P_PULL_SET;
                OP_RTI:
                begin
                    ps_q = stack_pull() | P_PULL_SET;
                    t = stack_pull();
                    r.npc = {stack_pull(), t};
                    r.pcl = 1'b1;
                end
                OP_RTS:
                begin
                    t = stack_pull();
                    r.npc = {stack_pull(), t} + 16'd1;
                    r.pcl = 1'b1;
                end
                OP_ASR:
                begin
                    acc_q &= v;
                    ps_q[FLAG_C] = acc_q[0];
                    acc_q = acc_q >> 1;
                    ps_q = with_nz(ps_q, acc_q);
                end
                OP_PLA: begin acc_q = stack_pull(); ps_q = with_nz(ps_q, acc_q); end
                OP_PHA: stack_push(acc_q);
                OP_STA: begin r.wd = acc_q; r.we = 1'b1; end
                OP_AAX: begin r.wd = xr_q & acc_q; r.we = 1'b1; end
                OP_STX: begin r.wd = xr_q; r.we = 1'b1; end
                OP_STY: begin r.wd = yr_q; r.we = 1'b1; end
                OP_TYA: begin acc_q = yr_q; ps_q = with_nz(ps_q, acc_q); end
                OP_TXA: begin acc_q = xr_q; ps_q = with_nz(ps_q, acc_q); end
                OP_TAY: begin yr_q = acc_q; ps_q = with_nz(ps_q, yr_q); end
                OP_TAX: begin xr_q = acc_q; ps_q = with_nz(ps_q, xr_q); end
                OP_TXS: sp_q = xr_q;
                OP_TSX: begin xr_q = sp_q; ps_q = with_nz(ps_q, xr_q); end
                OP_XAS, OP_SYA, OP_SXA, OP_XAA: begin acc_q &= v; ps_q = with_nz(ps_q, acc_q); end
                OP_LAR: begin acc_q = v; xr_q = sp_q; ps_q = with_nz(ps_q, xr_q); end
                OP_INY: begin yr_q += 8'd1; ps_q = with_nz(ps_q, yr_q); end
                OP_DEY: begin yr_q -= 8'd1; ps_q = with_nz(ps_q, yr_q); end
                OP_INX: begin xr_q += 8'd1; ps_q = with_nz(ps_q, xr_q); end
                OP_DEX: begin xr_q -= 8'd1; ps_q = with_nz(ps_q, xr_q); end
                OP_AXS:
                begin
                    t = acc_q & xr_q;
                    ps_q[FLAG_C] = (t >= v);
                    xr_q = t - v;
                    ps_q = with_nz(ps_q, xr_q);
                end
                default: ;
            endcase
            if (branch && take)
            begin
                r.pcl = 1'b1;
                r.npc = tgt;
                r.extra = (tgt[15:8] != pcv[15:8]) ? 2'd2 : 2'd1;
            end
        end
        r.halted = locked_q;
        r.a = acc_q;
        r.x = xr_q;
        r.y = yr_q;
        r.p = ps_q;
        r.sp = sp_q;
        return r;
    endfunction

    // number of stack entries an instruction pulls
    function automatic int pull_depth(input logic [6:0] op);
        case (op)
            OP_PLP, OP_PLA: return 1;
            OP_RTS: return 2;
            OP_RTI: return 3;
            default: return 0;
        endcase
    endfunction

    function automatic bit pull_is_safe(input logic [6:0] op);
        logic [7:0] idx;
        idx = sp_q;
        for (int i = 0; i < pull_depth(op); i++)
        begin
            idx = idx + 8'd1;
            if (!stack_known[idx])
                return 0;
        end
        return 1;
    endfunction

    function automatic logic [6:0] pick_op();
        logic [6:0] op;
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            op = 7'($urandom_range(81, 127));
        else if (r < 22)
        begin
            case ($urandom_range(0, 7))
                0: op = OP_PHA;
                1: op = OP_PHP;
                2: op = OP_JSR;
                3: op = OP_BRK;
                4: op = OP_PLA;
                5: op = OP_PLP;
                6: op = OP_RTS;
                default: op = OP_RTI;
            endcase
        end
        else
            op = 7'($urandom_range(0, 80));
        if (op == OP_KIL)
            op = OP_NOP;
        if (!pull_is_safe(op))
            op = $urandom_range(0, 1) ? OP_PHA : OP_JSR;
        return op;
    endfunction

    // one request: hold until accepted, then predict
    task automatic send_request(input logic [6:0] op, input logic [7:0] v,
                                input logic [15:0] tgt, input logic [15:0] pcv,
                                input bit typed, input cpu_result_t want);
        cpu_result_t r;
        if (burst_left == 0)
        begin
            int gap;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        func <= op;
        operand <= v;
        target <= tgt;
        pc <= pcv;
        @(posedge clk);
        while (in_stall_s)
            @(posedge clk);
        r = execute_instr(op, v, tgt, pcv);
        expected_results.push_back(typed ? want : r);
    endtask

    task automatic send_random();
        logic [6:0]  op;
        logic [15:0] pcv, tgt;
        op = pick_op();
        pcv = 16'($urandom);
        tgt = $urandom_range(0, 1) ? {pcv[15:8], 8'($urandom)} : 16'($urandom);
        send_request(op, 8'($urandom), tgt, pcv, 1'b0, '0);
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            failed = 1'b1;
        end
    endtask

    // sample outputs away from the driving edge
    always @(negedge clk)
    begin
        in_stall_s <= in_stall;
        res_valid_s <= out_valid;
        res_stall_s <= out_stall;
        res_s <= '{write_enable, write_data, pc_load, new_pc, extra_cycles, halted,
                   acc_out, x_out, y_out, flags_out, sp_out};
    end

    always @(posedge clk)
    begin
        cpu_result_t e;
        if (rst_n && res_valid_s && !res_stall_s)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no request outstanding");
                failed = 1'b1;
            end
            else
            begin
                e = expected_results.pop_front();
                check_field("write_enable", 16'(e.we), 16'(res_s.we));
                check_field("write_data", 16'(e.wd), 16'(res_s.wd));
                check_field("pc_load", 16'(e.pcl), 16'(res_s.pcl));
                check_field("new_pc", e.npc, res_s.npc);
                check_field("extra_cycles", 16'(e.extra), 16'(res_s.extra));
                check_field("halted", 16'(e.halted), 16'(res_s.halted));
                check_field("acc_out", 16'(e.a), 16'(res_s.a));
                check_field("x_out", 16'(e.x), 16'(res_s.x));
                check_field("y_out", 16'(e.y), 16'(res_s.y));
                check_field("flags_out", 16'(e.p), 16'(res_s.p));
                check_field("sp_out", 16'(e.sp), 16'(res_s.sp));
            end
        end
    end

    // receiver stall pattern, mode changes whenever stall_count runs down to zero
    always @(posedge clk)
    begin
        if (stall_count == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_count <= 150;
        end
        else
            stall_count <= stall_count - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 9) < 3);
            2: out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= (stall_count % 5 < 2);
        endcase
    end

    initial
    begin
        dir_row_t dir[$];
        rst_n = 1'b0;
        in_valid <= 1'b0;
        func <= OP_NOP;
        operand <= 8'h00;
        target <= 16'h0000;
        pc <= 16'h0000;
        stall_mode = 0;
        stall_count = 0;
        burst_left = 0;
        failed = 1'b0;
        acc_q = 8'h00; xr_q = 8'h00; yr_q = 8'h00;
        ps_q = P_RESET; sp_q = SP_RESET; locked_q = 1'b0;
        foreach (stack_known[i])
        begin
            stack_known[i] = 1'b0;
            stack_mem[i] = 8'h00;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, stack wrap, branch page cross, returns, unknown operation
        dir.push_back('{OP_LDA, 8'h00, 16'h0000, 16'h0000, 1'b1,
                        '{0, 8'h00, 0, 16'h0000, 2'd0, 0, 8'h00, 8'h00, 8'h00, 8'h26, 8'hFD}});
        dir.push_back('{OP_LDA, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1,
                        '{0, 8'h00, 0, 16'h0000, 2'd0, 0, 8'hFF, 8'h00, 8'h00, 8'hA4, 8'hFD}});
        dir.push_back('{OP_ADC, 8'h01, 16'h0000, 16'h0000, 1'b1,
                        '{0, 8'h00, 0, 16'h0000, 2'd0, 0, 8'h00, 8'h00, 8'h00, 8'h27, 8'hFD}});
        dir.push_back('{OP_SBC, 8'h80, 16'h0000, 16'h0000, 1'b0, '0});
        dir.push_back('{OP_DCP, 8'h00, 16'h0000, 16'h0000, 1'b0, '0});
        dir.push_back('{OP_ISC, 8'hFF, 16'h0000, 16'h0000, 1'b0, '0});
        dir.push_back('{OP_JSR, 8'h00, 16'h0000, 16'hFFFF, 1'b0, '0});
        dir.push_back('{OP_RTS, 8'h00, 16'h0000, 16'h0000, 1'b0, '0});
        dir.push_back('{OP_BRK, 8'h00, 16'hFFFE, 16'hFFFF, 1'b0, '0});
        dir.push_back('{OP_RTI, 8'h00, 16'h0000, 16'h0000, 1'b0, '0});
        dir.push_back('{OP_PHP, 8'h00, 16'h0000, 16'h0000, 1'b0, '0});
        dir.push_back('{OP_PLP, 8'h00, 16'h0000, 16'h0000, 1'b0, '0});
        dir.push_back('{OP_LDX, 8'h00, 16'h0000, 16'h0000, 1'b0, '0});
        dir.push_back('{OP_TXS, 8'h00, 16'h0000, 16'h0000, 1'b0, '0});
        dir.push_back('{OP_PHA, 8'h00, 16'h0000, 16'h0000, 1'b0, '0});
        dir.push_back('{OP_PLA, 8'h00, 16'h0000, 16'h0000, 1'b0, '0});
        dir.push_back('{OP_SEC, 8'h00, 16'h0000, 16'h0000, 1'b0, '0});
        dir.push_back('{OP_BCS, 8'h00, 16'h1200, 16'h11FE, 1'b0, '0});
        dir.push_back('{OP_BCS, 8'h00, 16'h1210, 16'h12F0, 1'b0, '0});
        dir.push_back('{OP_BCC, 8'h00, 16'h3456, 16'h0000, 1'b0, '0});
        dir.push_back('{OP_LDX, 8'hFF, 16'h0000, 16'h0000, 1'b0, '0});
        dir.push_back('{OP_AXA, 8'h00, 16'h0000, 16'h0000, 1'b0, '0});
        dir.push_back('{OP_ARR, 8'hFF, 16'h0000, 16'h0000, 1'b0, '0});
        dir.push_back('{OP_UNKNOWN, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, '0});
        foreach (dir[i])
            send_request(dir[i].op, dir[i].opnd, dir[i].tgt, dir[i].pcv,
                         dir[i].typed, dir[i].want);

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n == NUM_RANDOM / 2)
            begin
                in_valid <= 1'b0;
                while (expected_results.size() != 0)
                    @(posedge clk);
                burst_left = 0;
            end
            send_random();
        end

        // lock the processor last: everything after it is ignored
        send_request(OP_KIL, 8'($urandom), 16'($urandom), 16'($urandom), 1'b0, '0);
        for (int n = 0; n < 6; n++)
            send_random();
        in_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (!failed && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
